[rtl/aus_pkg.sv]
// shared types and constants of the annex-b access unit splitter
`default_nettype none

package aus_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 5;
    // results one input byte can cause, and the counter width that holds that number
    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
    localparam logic [1:0] ZERO_RUN_SC = 2'd2;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
    localparam logic [KIND_W-1:0] VCL_FIRST = 5'd1;
    localparam logic [KIND_W-1:0] VCL_LAST = 5'd5;

    // the results of one input byte, emitted by the top level one per cycle while out_ready is high
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;       // number of results, 0 to 5
        logic [BYTE_W-1:0] data;      // input byte, sent as the final result when has_data
        logic [1:0]        one_pos;   // position of the 01 byte of a start code
        logic              has_one;
        logic              has_data;
        logic              nal;       // first result opens a nal unit
        logic [KIND_W-1:0] kind;
        logic              frame;     // first result opens an access unit
        logic              last;      // final result closes the stream
        logic              marker;    // single empty end marker
    } aus_pkt_t;

endpackage

`default_nettype wire

[rtl/aus_scan.sv]
// start code scanner: parser state and the result set of each byte
`default_nettype none

module aus_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [aus_pkg::BYTE_W-1:0]    data,
    input  wire logic                          last,
    output aus_pkg::aus_pkt_t                  pkt
);

    // held zeros; while a header is awaited, the zeros of that start code
    logic [1:0] zero_run_reg, zero_run_next;
    logic       inside_nal_reg, inside_nal_next;
    logic       await_header_reg, await_header_next;
    logic       prev_slice_reg, prev_slice_next;
    logic       frame_open_reg, frame_open_next;

    logic [1:0]                  zr_inc;
    logic [aus_pkg::KIND_W-1:0]  kind;
    logic                        vcl;
    logic                        drop_zero;

    assign zr_inc = (zero_run_reg == aus_pkg::ZERO_RUN_MAX) ? aus_pkg::ZERO_RUN_MAX
                                                             : zero_run_reg + 2'd1;
    assign kind = data[aus_pkg::KIND_W-1:0];
    assign vcl = (kind >= aus_pkg::VCL_FIRST) && (kind <= aus_pkg::VCL_LAST);
    assign drop_zero = (zero_run_reg == aus_pkg::ZERO_RUN_MAX) && inside_nal_reg;

    always_comb
    begin
        pkt = '0;
        pkt.data = data;
        zero_run_next = zero_run_reg;
        inside_nal_next = inside_nal_reg;
        await_header_next = await_header_reg;
        prev_slice_next = prev_slice_reg;
        frame_open_next = frame_open_reg;

        if (await_header_reg)
        begin
            // held zeros, the 01 byte, then the header byte
            pkt.cnt = {1'b0, zero_run_reg} + 3'd2;
            pkt.one_pos = zero_run_reg;
            pkt.has_one = 1'b1;
            pkt.has_data = 1'b1;
            pkt.nal = 1'b1;
            pkt.kind = kind;
            pkt.frame = !frame_open_reg || prev_slice_reg;
            prev_slice_next = vcl;
            frame_open_next = 1'b1;
            inside_nal_next = 1'b1;
            await_header_next = 1'b0;
            zero_run_next = 2'd0;
        end
        else if (data == aus_pkg::ZERO_BYTE)
        begin
            // oldest zero leaves once the run is full; at the end all held zeros go
            pkt.cnt = {2'b00, drop_zero}
                    + ((last && inside_nal_reg) ? {1'b0, zr_inc} : 3'd0);
            zero_run_next = zr_inc;
        end
        else if (data == aus_pkg::START_BYTE && zero_run_reg >= aus_pkg::ZERO_RUN_SC)
        begin
            await_header_next = 1'b1;
        end
        else
        begin
            if (inside_nal_reg)
            begin
                pkt.cnt = {1'b0, zero_run_reg} + 3'd1;
                pkt.has_data = 1'b1;
            end
            zero_run_next = 2'd0;
        end

        if (last)
        begin
            pkt.last = 1'b1;
            if (pkt.cnt == '0)
            begin
                pkt.cnt = 3'd1;
                pkt.marker = 1'b1;
            end
            zero_run_next = 2'd0;
            inside_nal_next = 1'b0;
            await_header_next = 1'b0;
            prev_slice_next = 1'b0;
            frame_open_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= 2'd0;
            inside_nal_reg <= 1'b0;
            await_header_reg <= 1'b0;
            prev_slice_reg <= 1'b0;
            frame_open_reg <= 1'b0;
        end
        else if (advance)
        begin
            zero_run_reg <= zero_run_next;
            inside_nal_reg <= inside_nal_next;
            await_header_reg <= await_header_next;
            prev_slice_reg <= prev_slice_next;
            frame_open_reg <= frame_open_next;
        end
    end

    // a start code needs at least two zeros before its 01 byte
    assert property (@(posedge clk) disable iff (!rst_n)
        await_header_reg |-> zero_run_reg >= aus_pkg::ZERO_RUN_SC)
        else $error("awaiting a header without a full start code");

    // an opened nal unit always leaves a frame open
    assert property (@(posedge clk) disable iff (!rst_n)
        inside_nal_reg |-> frame_open_reg)
        else $error("nal unit open outside any access unit");

    // the stream end returns the scanner to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> !inside_nal_reg && !await_header_reg && zero_run_reg == 2'd0)
        else $error("parser state survived the final byte");

endmodule

`default_nettype wire

[rtl/annexb_access_unit_splitter.sv]
// Annex-B access unit splitter: takes one stream byte per request and
// returns the kept bytes, marked with nal unit starts, the nal unit type and
// access unit starts. A byte is registered, then decoded against the parser
// state in one pass into a set of 0 to 5 results held in a result register,
// which sends them one per cycle while out_ready is high. A byte that yields n
// results holds the output until all n are sent, and the next byte waits in
// the input register meanwhile. Zeros and start code bytes yield no result
// until their fate is known (at most three zeros and the 01 byte are held);
// the final byte flushes them and is marked last, or an empty end marker is
// sent if nothing remains.
`default_nettype none

module annexb_access_unit_splitter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [aus_pkg::BYTE_W-1:0]  in_byte,
    input  wire logic                        in_last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [aus_pkg::BYTE_W-1:0]       out_byte,
    output logic                             byte_valid,
    output logic                             nal_begin,
    output logic [aus_pkg::KIND_W-1:0]       nal_kind,
    output logic                             frame_begin,
    output logic                             out_last
);

    logic                        inreg_valid_reg;
    logic [aus_pkg::BYTE_W-1:0]  inreg_byte_reg;
    logic                        inreg_last_reg;

    aus_pkg::aus_pkt_t           scan_pkt;
    aus_pkg::aus_pkt_t           pkt_reg;
    logic                        pkt_valid_reg;
    logic [aus_pkg::CNT_W-1:0]   idx_reg;

    logic last_item;
    logic pkt_free;
    logic advance;
    logic first_item;

    assign last_item = idx_reg == pkt_reg.cnt - 3'd1;
    assign pkt_free = !pkt_valid_reg || (out_ready && last_item);
    assign advance = inreg_valid_reg && pkt_free;
    assign in_ready = !inreg_valid_reg || advance;

    aus_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .data    (inreg_byte_reg),
        .last    (inreg_last_reg),
        .pkt     (scan_pkt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inreg_valid_reg <= 1'b0;
            pkt_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                inreg_valid_reg <= 1'b1;
            else if (advance)
                inreg_valid_reg <= 1'b0;

            if (advance)
            begin
                // a byte with no result leaves the result register empty
                pkt_valid_reg <= scan_pkt.cnt != '0;
                idx_reg <= '0;
            end
            else if (out_valid && out_ready)
            begin
                if (last_item)
                    pkt_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inreg_byte_reg <= in_byte;
            inreg_last_reg <= in_last;
        end
        if (advance)
            pkt_reg <= scan_pkt;
    end

    assign first_item = idx_reg == '0;

    always_comb
    begin
        if (pkt_reg.marker)
            out_byte = aus_pkg::ZERO_BYTE;
        else if (pkt_reg.has_data && last_item)
            out_byte = pkt_reg.data;
        else if (pkt_reg.has_one && idx_reg == {1'b0, pkt_reg.one_pos})
            out_byte = aus_pkg::START_BYTE;
        else
            out_byte = aus_pkg::ZERO_BYTE;
    end

    assign out_valid = pkt_valid_reg;
    assign byte_valid = !pkt_reg.marker;
    assign nal_begin = pkt_reg.nal && first_item;
    assign nal_kind = nal_begin ? pkt_reg.kind : '0;
    assign frame_begin = nal_begin && pkt_reg.frame;
    assign out_last = pkt_reg.last && last_item;

    // the send index never runs past the result count
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg |-> idx_reg < pkt_reg.cnt)
        else $error("result index beyond result count");

    // the empty end marker stands alone and closes the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg && pkt_reg.marker |-> pkt_reg.cnt == 3'd1 && pkt_reg.last)
        else $error("malformed end marker");

    // a nal unit start comes with its start code and header byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg && pkt_reg.nal |-> pkt_reg.cnt >= 3'd4 && pkt_reg.has_one)
        else $error("nal unit start without start code");

    // an empty input register always takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !inreg_valid_reg |-> in_ready)
        else $error("input stalled while empty");

endmodule

`default_nettype wire
